// ----- design/pr_pkg.sv -----
// shared constants, codes and types for the pagerank power iteration block
package pr_pkg;

	localparam int unsigned MAX_VERTICES_DEF   = 1024;
	localparam int unsigned MAX_EDGES_DEF      = 8192;
	localparam int unsigned RANK_FRAC_BITS_DEF = 31;

	localparam int unsigned OUT_W      = 14;
	localparam int unsigned OUT_CAP    = 16383;
	localparam int unsigned DIVIDEND_W = 33;
	localparam int unsigned RANK_W     = 32;
	localparam int unsigned SUM_W      = 48;

	localparam logic [10:0] VCOUNT_RESET = 11'd1024;
	localparam logic [15:0] DAMP_RESET   = 16'd55706;
	localparam logic [31:0] THR_RESET    = 32'd215;
	localparam logic [15:0] ILIM_RESET   = 16'd200;

	typedef enum logic [1:0] {
		ACT_LOAD,
		ACT_RUN,
		ACT_READ,
		ACT_CLEAR
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_CONV,
		STAT_LIMIT
	} status_t;

	typedef enum logic [1:0] {
		REG_VCOUNT,
		REG_DAMP,
		REG_THR,
		REG_ILIM
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_LD_WR,
		S_RD_OUT,
		S_RUN_ST,
		S_RUN_TEL,
		S_INIT,
		S_E_ADDR,
		S_E_FETCH,
		S_E_TEST,
		S_E_DIV,
		S_E_ACC,
		S_V_ADDR,
		S_V_MUL,
		S_V_SUM,
		S_V_WR,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

// ----- design/pagerank_power_iteration_top.sv -----
// pagerank power iteration over a loaded edge list, top level
// Input channel (in_valid/in_ready) takes one word with action and vertex
// fields; the output channel (out_valid/out_ready) returns one word per input.
// Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken and must only be written while the block is idle.
// Edge load goes through S_LD_WR and rank read through S_RD_OUT to S_DONE.
// Clear graph sweeps the out-degree memory one entry a cycle.
// Run: the shared divider forms the start rank and teleport term, ranks are
// initialised, then per iteration each edge is addressed, fetched and tested,
// and a counted edge waits on the divider for its share and is accumulated;
// each vertex gets the damping multiply and residual sum, then the residual is checked.
// The block works on one word at a time; in_ready is low while it works.
// A finished result sits in the output register; the next word is accepted
// while it waits, but that word's result holds until the receiver takes it.
// After reset the out-degree memory is cleared, while in_ready stays low.
// Edge and rank stores are undefined until written; a rank read before any
// run is not meaningful.
module pagerank_power_iteration_top #(
	parameter int unsigned MAX_VERTICES   = pr_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_EDGES      = pr_pkg::MAX_EDGES_DEF,
	parameter int unsigned RANK_FRAC_BITS = pr_pkg::RANK_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [9:0]  src_vertex,
	input  logic [9:0]  dst_vertex,
	input  logic [9:0]  query_vertex,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] rank_value,
	output logic [15:0] iterations_done,
	output logic [31:0] final_residual
);
	localparam int unsigned VAW   = $clog2(MAX_VERTICES);
	localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
	localparam int unsigned EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned ECW   = $clog2(MAX_EDGES + 1);
	localparam int unsigned OW    = pr_pkg::OUT_W;
	localparam int unsigned DIV_W = (NW > OW) ? NW : OW;
	localparam int unsigned DW    = pr_pkg::DIVIDEND_W;
	localparam int unsigned SW    = pr_pkg::SUM_W;

	// configuration
	logic [10:0] vcount_q;
	logic [15:0] damp_q;
	logic [31:0] thr_q;
	logic [15:0] ilim_q;
	logic [NW-1:0] n_eff;
	logic [15:0]   limit_eff;

	// memories
	logic [2*VAW-1:0] edge_mem [MAX_EDGES];
	logic [OW-1:0]    oc_mem   [MAX_VERTICES];
	logic [31:0]      rank_mem [MAX_VERTICES];
	logic [SW-1:0]    acc_mem  [MAX_VERTICES];
	logic [2*VAW-1:0] edge_rd_q;
	logic [OW-1:0]    oc_rd_q;
	logic [31:0]      rank_rd_q;
	logic [SW-1:0]    acc_rd_q;

	logic             edge_we;
	logic [EAW-1:0]   edge_wa;
	logic [EAW-1:0]   edge_ra;
	logic [2*VAW-1:0] edge_wd;
	logic             oc_we;
	logic [VAW-1:0]   oc_wa;
	logic [VAW-1:0]   oc_ra;
	logic [OW-1:0]    oc_wd;
	logic             rank_we;
	logic [VAW-1:0]   rank_wa;
	logic [VAW-1:0]   rank_ra;
	logic [31:0]      rank_wd;
	logic             acc_we;
	logic [VAW-1:0]   acc_wa;
	logic [VAW-1:0]   acc_ra;
	logic [SW-1:0]    acc_wd;

	// control
	pr_pkg::state_t  state_q, state_d;
	pr_pkg::action_t act;
	logic [ECW-1:0]  edge_total_q;
	logic [ECW-1:0]  e_q;
	logic [NW-1:0]   v_q;
	logic [VAW-1:0]  clr_q;
	logic            clr_cmd_q;
	logic [15:0]     it_q;
	logic [15:0]     it_next;
	logic [15:0]     run_iter_q;
	logic [31:0]     run_resid_q;
	logic            out_valid_q;
	logic            out_free;

	// datapath
	logic [VAW-1:0]        src_q;
	logic [9:0]            qry_q;
	logic [31:0]           start_q;
	logic [DW-1:0]         tel_q;
	logic [39:0]           mlo_q;
	logic [39:0]           mhi_q;
	logic [31:0]           nv_q;
	logic [31:0]           resid_q;
	pr_pkg::status_t       res_status_q;
	logic [31:0]           res_rank_q;
	logic [1:0]            status_q;
	logic [31:0]           rank_out_q;
	logic [15:0]           iter_out_q;
	logic [31:0]           resid_out_q;

	logic [VAW-1:0]  e_src;
	logic [VAW-1:0]  e_dst;
	logic            e_skip;
	logic            src_ok;
	logic            dst_ok;
	logic [SW:0]     acc_sum;
	logic [SW-1:0]   acc_sat;
	logic [63:0]     prod;
	logic [SW:0]     nv_full;
	logic [31:0]     nv_sat;
	logic [31:0]     diff;
	logic [32:0]     resid_sum;

	logic              div_start;
	logic              div_done;
	logic [DW-1:0]     div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic [DW-1:0]     div_quot;

	pr_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign act       = pr_pkg::action_t'(action);
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == pr_pkg::S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign it_next   = it_q + 16'd1;

	always_comb begin
		if (vcount_q == 11'd0) begin
			n_eff = NW'(1);
		end else if (32'(vcount_q) > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vcount_q);
		end
		limit_eff = (ilim_q == 16'd0) ? 16'd1 : ilim_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= pr_pkg::VCOUNT_RESET;
			damp_q   <= pr_pkg::DAMP_RESET;
			thr_q    <= pr_pkg::THR_RESET;
			ilim_q   <= pr_pkg::ILIM_RESET;
		end else if (cfg_valid) begin
			case (pr_pkg::reg_idx_t'(cfg_index))
				pr_pkg::REG_VCOUNT: vcount_q <= cfg_data[10:0];
				pr_pkg::REG_DAMP:   damp_q   <= cfg_data[15:0];
				pr_pkg::REG_THR:    thr_q    <= cfg_data;
				pr_pkg::REG_ILIM:   ilim_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// edge fields and arithmetic
	assign e_src   = edge_rd_q[2*VAW-1:VAW];
	assign e_dst   = edge_rd_q[VAW-1:0];
	assign e_skip  = (NW'(e_src) >= n_eff) || (NW'(e_dst) >= n_eff) || (oc_rd_q == '0);
	assign src_ok  = 32'(src_vertex) < MAX_VERTICES;
	assign dst_ok  = 32'(dst_vertex) < MAX_VERTICES;
	assign acc_sum = (SW+1)'(acc_rd_q) + (SW+1)'(div_quot);
	assign acc_sat = acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0];
	assign prod    = {mhi_q, 24'd0} + 64'(mlo_q);
	assign nv_full = (SW+1)'(tel_q) + (SW+1)'(prod[63:16]);
	assign nv_sat  = (nv_full[SW:32] != '0) ? 32'hFFFF_FFFF : nv_full[31:0];
	assign diff    = (nv_q >= rank_rd_q) ? (nv_q - rank_rd_q) : (rank_rd_q - nv_q);
	assign resid_sum = 33'(resid_q) + 33'(diff);

	// next state, memory strobes and divider requests
	always_comb begin
		state_d      = state_q;
		edge_we      = 1'b0;
		edge_wa      = edge_total_q[EAW-1:0];
		edge_wd      = {VAW'(src_vertex), VAW'(dst_vertex)};
		edge_ra      = e_q[EAW-1:0];
		oc_we        = 1'b0;
		oc_wa        = src_q;
		oc_wd        = (32'(oc_rd_q) >= pr_pkg::OUT_CAP) ? oc_rd_q : oc_rd_q + 1'b1;
		oc_ra        = e_src;
		rank_we      = 1'b0;
		rank_wa      = v_q[VAW-1:0];
		rank_wd      = nv_q;
		rank_ra      = e_src;
		acc_we       = 1'b0;
		acc_wa       = v_q[VAW-1:0];
		acc_wd       = '0;
		acc_ra       = e_dst;
		div_start    = 1'b0;
		div_dividend = DW'(rank_rd_q);
		div_divisor  = DIV_W'(oc_rd_q);
		unique case (state_q)
			pr_pkg::S_CLR: begin
				oc_we = 1'b1;
				oc_wa = clr_q;
				oc_wd = '0;
				if (32'(clr_q) == MAX_VERTICES - 1) begin
					state_d = clr_cmd_q ? pr_pkg::S_DONE : pr_pkg::S_IDLE;
				end
			end
			pr_pkg::S_IDLE: begin
				oc_ra   = VAW'(src_vertex);
				rank_ra = VAW'(query_vertex);
				if (in_valid) begin
					case (act)
						pr_pkg::ACT_LOAD: begin
							if (32'(edge_total_q) >= MAX_EDGES) begin
								state_d = pr_pkg::S_DONE;
							end else if (src_ok && dst_ok) begin
								edge_we = 1'b1;
								state_d = pr_pkg::S_LD_WR;
							end else begin
								state_d = pr_pkg::S_DONE;
							end
						end
						pr_pkg::ACT_RUN: begin
							div_start    = 1'b1;
							div_dividend = DW'(1) << RANK_FRAC_BITS;
							div_divisor  = DIV_W'(n_eff);
							state_d      = pr_pkg::S_RUN_ST;
						end
						pr_pkg::ACT_READ:  state_d = pr_pkg::S_RD_OUT;
						default:           state_d = pr_pkg::S_CLR;
					endcase
				end
			end
			pr_pkg::S_LD_WR: begin
				oc_we   = 1'b1;
				state_d = pr_pkg::S_DONE;
			end
			pr_pkg::S_RD_OUT: state_d = pr_pkg::S_DONE;
			pr_pkg::S_RUN_ST: begin
				div_dividend = DW'(17'h10000 - 17'(damp_q)) << (RANK_FRAC_BITS - 16);
				div_divisor  = DIV_W'(n_eff);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = pr_pkg::S_RUN_TEL;
				end
			end
			pr_pkg::S_RUN_TEL: begin
				if (div_done) begin
					state_d = pr_pkg::S_INIT;
				end
			end
			pr_pkg::S_INIT: begin
				if (v_q >= n_eff) begin
					state_d = pr_pkg::S_E_ADDR;
				end else begin
					rank_we = 1'b1;
					rank_wd = start_q;
					acc_we  = 1'b1;
				end
			end
			pr_pkg::S_E_ADDR: begin
				state_d = (e_q >= edge_total_q) ? pr_pkg::S_V_ADDR : pr_pkg::S_E_FETCH;
			end
			pr_pkg::S_E_FETCH: state_d = pr_pkg::S_E_TEST;
			pr_pkg::S_E_TEST: begin
				if (e_skip) begin
					state_d = pr_pkg::S_E_ADDR;
				end else begin
					div_start = 1'b1;
					state_d   = pr_pkg::S_E_DIV;
				end
			end
			pr_pkg::S_E_DIV: begin
				if (div_done) begin
					state_d = pr_pkg::S_E_ACC;
				end
			end
			pr_pkg::S_E_ACC: begin
				acc_we  = 1'b1;
				acc_wa  = e_dst;
				acc_wd  = acc_sat;
				state_d = pr_pkg::S_E_ADDR;
			end
			pr_pkg::S_V_ADDR: begin
				rank_ra = v_q[VAW-1:0];
				acc_ra  = v_q[VAW-1:0];
				state_d = (v_q >= n_eff) ? pr_pkg::S_CHECK : pr_pkg::S_V_MUL;
			end
			pr_pkg::S_V_MUL: begin
				rank_ra = v_q[VAW-1:0];
				acc_ra  = v_q[VAW-1:0];
				state_d = pr_pkg::S_V_SUM;
			end
			pr_pkg::S_V_SUM: begin
				rank_ra = v_q[VAW-1:0];
				acc_ra  = v_q[VAW-1:0];
				state_d = pr_pkg::S_V_WR;
			end
			pr_pkg::S_V_WR: begin
				rank_ra = v_q[VAW-1:0];
				acc_ra  = v_q[VAW-1:0];
				rank_we = 1'b1;
				acc_we  = 1'b1;
				state_d = pr_pkg::S_V_ADDR;
			end
			pr_pkg::S_CHECK: begin
				if (resid_q < thr_q || it_next == limit_eff) begin
					state_d = pr_pkg::S_DONE;
				end else begin
					state_d = pr_pkg::S_E_ADDR;
				end
			end
			pr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = pr_pkg::S_IDLE;
				end
			end
			default: state_d = pr_pkg::S_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_q <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (oc_we) begin
			oc_mem[oc_wa] <= oc_wd;
		end
		oc_rd_q <= oc_mem[oc_ra];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		rank_rd_q <= rank_mem[rank_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pr_pkg::S_CLR;
			edge_total_q <= '0;
			e_q          <= '0;
			v_q          <= '0;
			clr_q        <= '0;
			clr_cmd_q    <= 1'b0;
			it_q         <= '0;
			run_iter_q   <= '0;
			run_resid_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pr_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pr_pkg::S_CLR: begin
					clr_q <= clr_q + 1'b1;
				end
				pr_pkg::S_IDLE: begin
					v_q   <= '0;
					clr_q <= '0;
					if (in_valid) begin
						clr_cmd_q <= (act == pr_pkg::ACT_CLEAR);
						if (act == pr_pkg::ACT_CLEAR) begin
							edge_total_q <= '0;
						end
						if (edge_we) begin
							edge_total_q <= edge_total_q + 1'b1;
						end
					end
				end
				pr_pkg::S_INIT: begin
					if (v_q >= n_eff) begin
						e_q  <= '0;
						it_q <= '0;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				pr_pkg::S_E_ADDR: begin
					v_q <= '0;
				end
				pr_pkg::S_E_TEST: begin
					if (e_skip) begin
						e_q <= e_q + 1'b1;
					end
				end
				pr_pkg::S_E_ACC: begin
					e_q <= e_q + 1'b1;
				end
				pr_pkg::S_V_WR: begin
					v_q <= v_q + 1'b1;
				end
				pr_pkg::S_CHECK: begin
					run_iter_q  <= it_next;
					run_resid_q <= resid_q;
					it_q        <= it_next;
					e_q         <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pr_pkg::S_IDLE: begin
				src_q        <= VAW'(src_vertex);
				qry_q        <= query_vertex;
				res_status_q <= (in_valid && act == pr_pkg::ACT_LOAD &&
					32'(edge_total_q) >= MAX_EDGES) ? pr_pkg::STAT_FULL : pr_pkg::STAT_OK;
				res_rank_q   <= '0;
				resid_q      <= '0;
			end
			pr_pkg::S_RD_OUT: begin
				if (32'(qry_q) < 32'(n_eff)) begin
					res_rank_q <= rank_rd_q;
				end
			end
			pr_pkg::S_RUN_ST: begin
				if (div_done) begin
					start_q <= div_quot[31:0];
				end
			end
			pr_pkg::S_RUN_TEL: begin
				if (div_done) begin
					tel_q <= div_quot;
				end
			end
			pr_pkg::S_V_MUL: begin
				mlo_q <= damp_q * acc_rd_q[23:0];
				mhi_q <= damp_q * acc_rd_q[47:24];
			end
			pr_pkg::S_V_SUM: begin
				nv_q <= nv_sat;
			end
			pr_pkg::S_V_WR: begin
				resid_q <= resid_sum[32] ? 32'hFFFF_FFFF : resid_sum[31:0];
			end
			pr_pkg::S_CHECK: begin
				if (resid_q < thr_q) begin
					res_status_q <= pr_pkg::STAT_CONV;
				end else if (it_next == limit_eff) begin
					res_status_q <= pr_pkg::STAT_LIMIT;
				end
				resid_q <= '0;
			end
			pr_pkg::S_DONE: begin
				if (out_free) begin
					status_q    <= res_status_q;
					rank_out_q  <= res_rank_q;
					iter_out_q  <= run_iter_q;
					resid_out_q <= run_resid_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign rank_value      = rank_out_q;
	assign iterations_done = iter_out_q;
	assign final_residual  = resid_out_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted word");

	a_rank_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_value != 32'd0 |-> status == pr_pkg::STAT_OK)
		else $error("rank returned with a non-ok status");

	a_run_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pr_pkg::STAT_CONV || status == pr_pkg::STAT_LIMIT)
		|-> iterations_done != 16'd0)
		else $error("run finished with no iteration counted");

	a_conv_below_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pr_pkg::STAT_CONV |-> final_residual < thr_q)
		else $error("converged with residual at or above threshold");

endmodule

// ----- design/pr_div.sv -----
// restoring divider, one quotient bit per cycle
module pr_div #(
	parameter int unsigned DIV_W = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pr_pkg::DIVIDEND_W-1:0]       dividend,
	input  logic [DIV_W-1:0]                    divisor,
	output logic                                done,
	output logic [pr_pkg::DIVIDEND_W-1:0]       quotient
);
	localparam int unsigned CW = $clog2(pr_pkg::DIVIDEND_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic [pr_pkg::DIVIDEND_W-1:0] quot_q;
	logic [DIV_W-1:0]              rem_q;
	logic [DIV_W-1:0]              div_q;
	logic [DIV_W:0]                trial;
	logic [DIV_W:0]                diff;
	logic                          ge;

	assign trial = {rem_q, quot_q[pr_pkg::DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(pr_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[pr_pkg::DIVIDEND_W-2:0], ge};
			rem_q  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
